/* rtl/fcc_pkg.sv */
// Shared types, constants and the byte-wide CRC-32 update for the frame checker.
// No dependencies; every other file imports this package.
package fcc_pkg;

    localparam int unsigned FRAME_OVERHEAD = 16;
    localparam int unsigned CFG_IDX_W      = 1;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    // Frame magic, first byte on the wire first
    localparam logic [7:0] MAGIC [4] = '{8'h47, 8'h44, 8'h46, 8'h31};

    // Byte positions of the header fields
    localparam logic [31:0] POS_MAGIC_END = 32'd4;
    localparam logic [31:0] POS_VER_LO    = 32'd4;
    localparam logic [31:0] POS_VER_HI    = 32'd5;
    localparam logic [31:0] POS_TYPE      = 32'd6;
    localparam logic [31:0] POS_FLAGS     = 32'd7;
    localparam logic [31:0] POS_LEN_END   = 32'd11;
    localparam logic [31:0] POS_PAYLOAD   = 32'd12;

    // Known message types
    localparam logic [7:0] TYPE_MIN   = 8'd1;
    localparam logic [7:0] TYPE_MAX   = 8'd9;
    localparam logic [7:0] TYPE_EXT_A = 8'd40;
    localparam logic [7:0] TYPE_EXT_B = 8'd41;

    localparam logic [15:0] VERSION_RST     = 16'd1;
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'h0100_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_VERSION = 1'd0,
        CFG_MAX_PAYLOAD      = 1'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_MAGIC    = 3'd2,
        ST_VERSION  = 3'd3,
        ST_TOO_LONG = 3'd4,
        ST_SIZE     = 3'd5,
        ST_CHECKSUM = 3'd6,
        ST_TYPE     = 3'd7
    } t_status;

    typedef struct packed {
        logic [15:0] expected_version;
        logic [31:0] max_payload;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic        is_status;
        logic [7:0]  payload_byte;
        t_status     status;
        logic [7:0]  msg_type;
        logic [7:0]  frame_flags;
        logic [31:0] payload_length;
    } t_result;

    // Reflected CRC-32, one byte, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
        end
        return x;
    endfunction

    function automatic logic type_known(input logic [7:0] t);
        return ((t >= TYPE_MIN) && (t <= TYPE_MAX)) || (t == TYPE_EXT_A) || (t == TYPE_EXT_B);
    endfunction

endpackage

/* rtl/fcc_ifs.sv */
// Valid/ready channel interfaces of the frame checker: byte input, result output, config writes.
// Depends on fcc_pkg for the config index width.
interface fcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface fcc_out_if;
    logic        valid;
    logic        ready;
    logic        is_status;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [7:0]  msg_type;
    logic [7:0]  frame_flags;
    logic [31:0] payload_length;

    modport source (output valid, output is_status, output payload_byte, output status,
                    output msg_type, output frame_flags, output payload_length, input ready);
    modport sink   (input valid, input is_status, input payload_byte, input status,
                    input msg_type, input frame_flags, input payload_length, output ready);
endinterface

interface fcc_cfg_if import fcc_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/fcc_cfg_regs.sv */
// Configuration registers: expected header version and payload length limit.
// Depends on fcc_pkg and fcc_cfg_if.
module fcc_cfg_regs import fcc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fcc_cfg_if.sink       i_cfg,
    output t_cfg          o_cfg
);
    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_version <= VERSION_RST;
            r_cfg.max_payload      <= MAX_PAYLOAD_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_EXPECTED_VERSION: r_cfg.expected_version <= i_cfg.data[15:0];
                CFG_MAX_PAYLOAD:      r_cfg.max_payload      <= i_cfg.data;
                default: ;
            endcase
        end
    end
endmodule

/* rtl/fcc_in_stage.sv */
// Input register: holds one accepted byte item until the frame engine takes it.
// Depends on fcc_pkg and fcc_in_if.
module fcc_in_stage import fcc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    fcc_in_if.sink   i_in,
    input  logic     i_take,
    output logic     o_vld,
    output t_in_item o_item
);
    logic     r_vld;
    t_in_item r_item;

    assign i_in.ready = !r_vld || i_take;
    assign o_vld      = r_vld;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.data_byte <= i_in.data_byte;
            r_item.last      <= i_in.last;
        end
    end
endmodule

/* rtl/fcc_engine.sv */
// Frame engine: header capture, CRC update, tail byte line and end-of-frame checks.
// Depends on fcc_pkg.
module fcc_engine import fcc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output logic     o_push,
    output t_result  o_res
);
    logic [31:0] r_count, n_count;
    logic [31:0] r_crc, n_crc;
    logic [7:0]  r_tail [4];
    logic [7:0]  n_tail [4];
    logic        r_magic_ok, n_magic_ok;
    logic [15:0] r_ver, n_ver;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_flags, n_flags;
    logic [31:0] r_len, n_len;

    // Frame state after this byte, before any end-of-frame clear
    logic        upd_magic_ok;
    logic [15:0] upd_ver;
    logic [7:0]  upd_type;
    logic [7:0]  upd_flags;
    logic [31:0] upd_len;
    logic [31:0] upd_crc;
    logic        sat;
    logic        in_pay;
    logic [31:0] stored;
    t_status     st;

    always_comb begin
        upd_magic_ok = r_magic_ok;
        upd_ver      = r_ver;
        upd_type     = r_type;
        upd_flags    = r_flags;
        upd_len      = r_len;
        sat          = &r_count;

        if (r_count < POS_MAGIC_END) begin
            if (i_item.data_byte != MAGIC[r_count[1:0]]) begin
                upd_magic_ok = 1'b0;
            end
        end else if (r_count == POS_VER_LO) begin
            upd_ver[7:0] = i_item.data_byte;
        end else if (r_count == POS_VER_HI) begin
            upd_ver[15:8] = i_item.data_byte;
        end else if (r_count == POS_TYPE) begin
            upd_type = i_item.data_byte;
        end else if (r_count == POS_FLAGS) begin
            upd_flags = i_item.data_byte;
        end else if (r_count <= POS_LEN_END) begin
            upd_len[{r_count[1:0], 3'b000} +: 8] = i_item.data_byte;
        end

        // r_tail[0] is the byte four positions back
        upd_crc = (r_count >= POS_MAGIC_END) ? crc_byte(r_crc, r_tail[0]) : r_crc;

        // Once the count saturates the oldest slot is recycled for every new byte
        if (sat) begin
            n_tail[0] = i_item.data_byte;
            n_tail[1] = r_tail[1];
            n_tail[2] = r_tail[2];
            n_tail[3] = r_tail[3];
        end else begin
            n_tail[0] = r_tail[1];
            n_tail[1] = r_tail[2];
            n_tail[2] = r_tail[3];
            n_tail[3] = i_item.data_byte;
        end

        in_pay = (r_count >= POS_PAYLOAD) && ((r_count - POS_PAYLOAD) < r_len);
        stored = {i_item.data_byte, r_tail[3], r_tail[2], r_tail[1]};

        priority if (r_count < 32'(FRAME_OVERHEAD - 1)) begin
            st = ST_SHORT;
        end else if (!upd_magic_ok) begin
            st = ST_MAGIC;
        end else if (upd_ver != i_cfg.expected_version) begin
            st = ST_VERSION;
        end else if (upd_len > i_cfg.max_payload) begin
            st = ST_TOO_LONG;
        end else if (({1'b0, r_count} + 33'd1) != ({1'b0, upd_len} + 33'(FRAME_OVERHEAD))) begin
            st = ST_SIZE;
        end else if (stored != (upd_crc ^ CRC_ONES)) begin
            st = ST_CHECKSUM;
        end else if (!type_known(upd_type)) begin
            st = ST_TYPE;
        end else begin
            st = ST_OK;
        end

        if (i_item.last) begin
            n_count    = 32'd0;
            n_crc      = CRC_ONES;
            n_magic_ok = 1'b1;
            n_ver      = 16'd0;
            n_type     = 8'd0;
            n_flags    = 8'd0;
            n_len      = 32'd0;
        end else begin
            n_count    = sat ? r_count : r_count + 32'd1;
            n_crc      = upd_crc;
            n_magic_ok = upd_magic_ok;
            n_ver      = upd_ver;
            n_type     = upd_type;
            n_flags    = upd_flags;
            n_len      = upd_len;
        end
    end

    always_comb begin
        o_push = i_adv && (i_item.last || in_pay);
        if (i_item.last) begin
            o_res.is_status      = 1'b1;
            o_res.payload_byte   = 8'd0;
            o_res.status         = st;
            o_res.msg_type       = upd_type;
            o_res.frame_flags    = upd_flags;
            o_res.payload_length = upd_len;
        end else begin
            o_res.is_status      = 1'b0;
            o_res.payload_byte   = i_item.data_byte;
            o_res.status         = ST_OK;
            o_res.msg_type       = 8'd0;
            o_res.frame_flags    = 8'd0;
            o_res.payload_length = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= 32'd0;
            r_crc      <= CRC_ONES;
            r_magic_ok <= 1'b1;
            r_ver      <= 16'd0;
            r_type     <= 8'd0;
            r_flags    <= 8'd0;
            r_len      <= 32'd0;
        end else if (i_adv) begin
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_magic_ok <= n_magic_ok;
            r_ver      <= n_ver;
            r_type     <= n_type;
            r_flags    <= n_flags;
            r_len      <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tail <= n_tail;
        end
    end
endmodule

/* rtl/fcc_out_buf.sv */
// Two-entry result buffer; decouples the output handshake from the engine.
// Depends on fcc_pkg and fcc_out_if.
module fcc_out_buf import fcc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_result   i_res,
    output logic      o_full,
    fcc_out_if.source o_out
);
    t_result    r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;
    t_result    head;

    assign pop    = o_out.valid && o_out.ready;
    assign o_full = (r_cnt == 2'd2);
    assign head   = r_mem[r_rd_ptr];

    assign o_out.valid          = (r_cnt != 2'd0);
    assign o_out.is_status      = head.is_status;
    assign o_out.payload_byte   = head.payload_byte;
    assign o_out.status         = head.status;
    assign o_out.msg_type       = head.msg_type;
    assign o_out.frame_flags    = head.frame_flags;
    assign o_out.payload_length = head.payload_length;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end
endmodule

/* rtl/crc32_frame_checker_core.sv */
// Frame checker top level: input register, frame engine, two-entry result buffer.
// Throughput one byte item per cycle; an accepted item waits in the input register and its result
// is written into the result buffer when the engine advances; a full result buffer stalls the input.
// The frame engine's per-byte header capture and byte-wide CRC update set that rate.
// Synchronous active-low reset empties both stages, restarts the frame state and
// restores the configuration registers to their defaults.
module crc32_frame_checker_core import fcc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fcc_in_if.sink    i_in,
    fcc_out_if.source o_out,
    fcc_cfg_if.sink   i_cfg
);
    t_cfg     cfg;
    logic     item_vld;
    t_in_item item;
    logic     take;
    logic     push;
    t_result  res;
    logic     full;

    // Advance the engine only when the result buffer has room
    assign take = item_vld && !full;

    fcc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    fcc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_vld   (item_vld),
        .o_item  (item)
    );

    fcc_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (take),
        .i_item  (item),
        .i_cfg   (cfg),
        .o_push  (push),
        .o_res   (res)
    );

    fcc_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_full  (full),
        .o_out   (o_out)
    );
endmodule

/* tb/tb_crc32_frame_checker_core.sv */
// Testbench for crc32_frame_checker_core: sends byte frames and register writes with random
// idling on both channels, predicts every payload and status item, and checks the output.
// Depends on fcc_pkg and on the channel interfaces in fcc_ifs.sv.
module tb_crc32_frame_checker_core;
    import fcc_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_BYTES  = 160;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;

    typedef enum int {
        FK_GOOD, FK_TYPE, FK_MAGIC, FK_VERSION, FK_TOO_LONG, FK_CRC, FK_CUT, FK_SHORT, FK_NOISE
    } t_frame_kind;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_ALTERNATE} t_rx_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    fcc_in_if  in_if();
    fcc_out_if out_if();
    fcc_cfg_if cfg_if();

    crc32_frame_checker_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Frame tracker state and register copies
    logic [31:0] fm_count;
    logic [31:0] fm_crc;
    logic [7:0]  fm_tail [4];
    logic        fm_magic_ok;
    logic [15:0] fm_version;
    logic [7:0]  fm_type;
    logic [7:0]  fm_flags;
    logic [31:0] fm_length;
    logic [15:0] cfg_version;
    logic [31:0] cfg_max_payload;

    t_result expected_items [$];

    int errors;
    int cycles;
    int bytes_sent;
    int frames_sent;
    int payload_seen;
    int status_seen [8];
    int burst_left;
    int hold_request;
    bit stall_seen;

    function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c;
        for (int k = 0; k < 8; k++) begin
            if (r[0] ^ b[k]) r = (r >> 1) ^ CRC_POLY;
            else r = r >> 1;
        end
        return r;
    endfunction

    function automatic bit msg_type_accepted(input logic [7:0] t);
        return t inside {[TYPE_MIN:TYPE_MAX], TYPE_EXT_A, TYPE_EXT_B};
    endfunction

    function automatic logic [7:0] pick_known_type();
        int r;
        r = $urandom_range(0, 10);
        if (r <= 8) return TYPE_MIN + 8'(r);
        return (r == 9) ? TYPE_EXT_A : TYPE_EXT_B;
    endfunction

    function automatic logic [7:0] pick_unknown_type();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'($urandom_range(TYPE_MAX + 1, TYPE_EXT_A - 1));
            2: return 8'($urandom_range(TYPE_EXT_B + 1, 255));
            default: return 8'hFF;
        endcase
    endfunction

    task automatic clear_frame();
        fm_count    = '0;
        fm_crc      = CRC_ONES;
        fm_magic_ok = 1'b1;
        fm_version  = '0;
        fm_type     = '0;
        fm_flags    = '0;
        fm_length   = '0;
        foreach (fm_tail[k]) fm_tail[k] = '0;
    endtask

    // Advance the frame tracker by one accepted byte and queue the item it causes
    task automatic track_byte(input logic [7:0] b, input logic is_last);
        logic [31:0] p;
        logic [63:0] n;
        logic [31:0] stored;
        logic [1:0]  q0, q1, q2, q3;
        bit          in_payload;
        t_result     r;
        t_status     st;
        p = fm_count;
        if (p < 4) begin
            if (b != MAGIC[p[1:0]]) fm_magic_ok = 1'b0;
        end else if (p == POS_VER_LO) begin
            fm_version[7:0] = b;
        end else if (p == POS_VER_HI) begin
            fm_version[15:8] = b;
        end else if (p == POS_TYPE) begin
            fm_type = b;
        end else if (p == POS_FLAGS) begin
            fm_flags = b;
        end else if (p <= POS_LEN_END) begin
            fm_length[int'(p[1:0]) * 8 +: 8] = b;
        end
        // CRC trails by four bytes so the stored checksum never enters it
        if (p >= 4) fm_crc = crc32_next(fm_crc, fm_tail[p[1:0]]);
        fm_tail[p[1:0]] = b;
        in_payload = (p >= POS_PAYLOAD) && ((p - POS_PAYLOAD) < fm_length);
        if (fm_count != 32'hFFFF_FFFF) fm_count = fm_count + 1;
        r = '0;
        if (is_last) begin
            n  = {32'd0, p} + 64'd1;
            q0 = p[1:0];
            q1 = q0 - 2'd1;
            q2 = q0 - 2'd2;
            q3 = q0 - 2'd3;
            stored = {fm_tail[q0], fm_tail[q1], fm_tail[q2], fm_tail[q3]};
            if (n < FRAME_OVERHEAD) st = ST_SHORT;
            else if (!fm_magic_ok) st = ST_MAGIC;
            else if (fm_version != cfg_version) st = ST_VERSION;
            else if (fm_length > cfg_max_payload) st = ST_TOO_LONG;
            else if (n != 64'(FRAME_OVERHEAD) + {32'd0, fm_length}) st = ST_SIZE;
            else if (stored != ~fm_crc) st = ST_CHECKSUM;
            else if (!msg_type_accepted(fm_type)) st = ST_TYPE;
            else st = ST_OK;
            r.is_status      = 1'b1;
            r.status         = st;
            r.msg_type       = fm_type;
            r.frame_flags    = fm_flags;
            r.payload_length = fm_length;
            expected_items = {expected_items, r};
            clear_frame();
        end else if (in_payload) begin
            r.is_status    = 1'b0;
            r.status       = ST_OK;
            r.payload_byte = b;
            expected_items = {expected_items, r};
        end
    endtask

    // Offer one item in bursts with random gaps; enter and leave at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        in_if.last      <= is_last;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) begin
            stall_seen = 1'b1;
            @(posedge i_clk);
        end
        track_byte(b, is_last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        in_if.valid <= 1'b0;
        while (expected_items.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1) @(posedge i_clk);
        if (idx == CFG_EXPECTED_VERSION) cfg_version = value[15:0];
        else cfg_max_payload = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Build a frame and send it; cut > 0 trims or pads the wire length, fill < 0 means random
    task automatic send_frame(input logic [15:0] ver, input logic [7:0] mtype,
                              input logic [7:0] flags, input logic [31:0] len_field,
                              input int payload_n, input bit bad_magic, input bit bad_crc,
                              input int cut, input int fill);
        logic [7:0]  fb [$];
        logic [31:0] crc;
        int          i;
        fb = {MAGIC[0], MAGIC[1], MAGIC[2], MAGIC[3], ver[7:0], ver[15:8], mtype, flags,
              len_field[7:0], len_field[15:8], len_field[23:16], len_field[31:24]};
        if (bad_magic) begin
            i = $urandom_range(0, 3);
            fb[i] = fb[i] ^ (8'd1 << $urandom_range(0, 7));
        end
        for (i = 0; i < payload_n; i++) fb = {fb, ((fill < 0) ? 8'($urandom) : 8'(fill))};
        crc = CRC_ONES;
        foreach (fb[k]) crc = crc32_next(crc, fb[k]);
        crc = ~crc;
        if (bad_crc) crc = crc ^ (32'd1 << $urandom_range(0, 31));
        fb = {fb, crc[7:0], crc[15:8], crc[23:16], crc[31:24]};
        if (cut > 0) begin
            while (fb.size() > cut) void'(fb.pop_back());
            while (fb.size() < cut) fb = {fb, 8'($urandom)};
        end
        foreach (fb[k]) send_byte(fb[k], k == fb.size() - 1);
        frames_sent++;
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 9) == 0));
        frames_sent++;
    endtask

    task automatic random_frame();
        t_frame_kind kind;
        int          r, lim, pn, full, cut;
        logic [15:0] ver;
        logic [7:0]  mt;
        logic [31:0] len;
        bit          bm, bc;
        r = $urandom_range(0, 99);
        if (r < 55) kind = FK_GOOD;
        else if (r < 61) kind = FK_TYPE;
        else if (r < 66) kind = FK_MAGIC;
        else if (r < 71) kind = FK_VERSION;
        else if (r < 76) kind = FK_TOO_LONG;
        else if (r < 82) kind = FK_CRC;
        else if (r < 89) kind = FK_CUT;
        else if (r < 95) kind = FK_SHORT;
        else kind = FK_NOISE;
        lim  = (cfg_max_payload < 24) ? int'(cfg_max_payload) : 24;
        pn   = $urandom_range(0, lim);
        len  = pn;
        ver  = cfg_version;
        mt   = pick_known_type();
        bm   = 1'b0;
        bc   = 1'b0;
        cut  = 0;
        full = FRAME_OVERHEAD + pn;
        case (kind)
            FK_TYPE:    mt = pick_unknown_type();
            FK_MAGIC:   bm = 1'b1;
            FK_VERSION: ver = cfg_version ^ (16'd1 << $urandom_range(0, 15));
            FK_TOO_LONG: begin
                if (cfg_max_payload < 32'hFFFF_0000)
                    len = cfg_max_payload + 1 + $urandom_range(0, 1000);
                else
                    len = 32'hFFFF_FFFF;
            end
            FK_CRC: bc = 1'b1;
            FK_CUT: begin
                if ($urandom_range(0, 1) == 0) cut = $urandom_range(13, full - 1);
                else cut = full + $urandom_range(1, 4);
            end
            FK_SHORT: cut = $urandom_range(1, FRAME_OVERHEAD - 1);
            default: ;
        endcase
        if (kind == FK_NOISE) send_noise();
        else send_frame(ver, mt, 8'($urandom), len, pn, bm, bc, cut, -1);
    endtask

    task automatic test_valid_frames();
        send_frame(cfg_version, TYPE_MIN, 8'h00, 32'd0, 0, 1'b0, 1'b0, 0, -1);
        send_frame(cfg_version, TYPE_MAX, 8'hFF, 32'd2, 2, 1'b0, 1'b0, 0, 8'hFF);
        send_frame(cfg_version, TYPE_EXT_A, 8'h5A, 32'd1, 1, 1'b0, 1'b0, 0, 8'h00);
        send_frame(cfg_version, TYPE_EXT_B, 8'hA5, 32'd3, 3, 1'b0, 1'b0, 0, -1);
    endtask

    task automatic test_frame_faults();
        // short frames: lone byte, partial version, one byte shy of a header plus checksum
        send_frame(cfg_version, TYPE_MIN, 8'h11, 32'd0, 0, 1'b0, 1'b0, 1, -1);
        send_frame(cfg_version, TYPE_MIN, 8'h11, 32'd0, 0, 1'b0, 1'b0, 5, -1);
        send_frame(cfg_version, TYPE_MIN, 8'h11, 32'd0, 0, 1'b0, 1'b0, 15, -1);
        send_frame(cfg_version, TYPE_MIN, 8'h22, 32'd1, 1, 1'b1, 1'b0, 0, -1);
        send_frame(cfg_version ^ 16'h8000, TYPE_MIN, 8'h33, 32'd0, 0, 1'b0, 1'b0, 0, -1);
        send_frame(cfg_version, TYPE_MIN, 8'h44, cfg_max_payload + 1, 2, 1'b0, 1'b0, 0, -1);
        // last byte lands inside the payload, then a frame that runs past its checksum
        send_frame(cfg_version, TYPE_MAX, 8'h55, 32'd4, 4, 1'b0, 1'b0, 14, -1);
        send_frame(cfg_version, TYPE_MAX, 8'h66, 32'd1, 1, 1'b0, 1'b0, 20, -1);
        send_frame(cfg_version, TYPE_MIN, 8'h77, 32'd2, 2, 1'b0, 1'b1, 0, -1);
        send_frame(cfg_version, 8'd0, 8'h88, 32'd0, 0, 1'b0, 1'b0, 0, -1);
        send_frame(cfg_version, TYPE_MAX + 8'd1, 8'h99, 32'd0, 0, 1'b0, 1'b0, 0, -1);
        send_frame(cfg_version, TYPE_EXT_A - 8'd1, 8'h99, 32'd0, 0, 1'b0, 1'b0, 0, -1);
        send_frame(cfg_version, TYPE_EXT_B + 8'd1, 8'h99, 32'd0, 0, 1'b0, 1'b0, 0, -1);
        send_frame(cfg_version, 8'hFF, 8'h99, 32'd0, 0, 1'b0, 1'b0, 0, -1);
        // magic outranks checksum
        send_frame(cfg_version, TYPE_MIN, 8'hAA, 32'd1, 1, 1'b1, 1'b1, 0, -1);
    endtask

    task automatic test_config_limits();
        write_reg(CFG_EXPECTED_VERSION, 32'd0);
        send_frame(16'h0000, TYPE_MIN, 8'h01, 32'd1, 1, 1'b0, 1'b0, 0, -1);
        send_frame(16'h0001, TYPE_MIN, 8'h02, 32'd1, 1, 1'b0, 1'b0, 0, -1);
        write_reg(CFG_EXPECTED_VERSION, 32'h0000_FFFF);
        send_frame(16'hFFFF, TYPE_MAX, 8'h03, 32'd0, 0, 1'b0, 1'b0, 0, -1);
        write_reg(CFG_MAX_PAYLOAD, 32'd0);
        send_frame(16'hFFFF, TYPE_MIN, 8'h04, 32'd0, 0, 1'b0, 1'b0, 0, -1);
        send_frame(16'hFFFF, TYPE_MIN, 8'h05, 32'd1, 1, 1'b0, 1'b0, 0, -1);
        write_reg(CFG_MAX_PAYLOAD, 32'd5);
        send_frame(16'hFFFF, TYPE_MIN, 8'h06, 32'd5, 5, 1'b0, 1'b0, 0, -1);
        send_frame(16'hFFFF, TYPE_MIN, 8'h07, 32'd6, 6, 1'b0, 1'b0, 0, -1);
        write_reg(CFG_MAX_PAYLOAD, 32'hFFFF_FFFF);
        send_frame(16'hFFFF, TYPE_MIN, 8'h08, 32'hFFFF_FFFF, 2, 1'b0, 1'b0, 0, -1);
        write_reg(CFG_EXPECTED_VERSION, 32'(VERSION_RST));
        write_reg(CFG_MAX_PAYLOAD, MAX_PAYLOAD_RST);
    endtask

    // Hold the output for a long stretch while a long frame keeps arriving
    task automatic test_output_hold();
        hold_request = HOLD_CYCLES;
        send_frame(cfg_version, TYPE_EXT_A, 8'($urandom), 32'd48, 48, 1'b0, 1'b0, 0, -1);
    endtask

    task automatic test_random_traffic();
        int start;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_EXPECTED_VERSION, 32'($urandom_range(0, 65535)));
                    write_reg(CFG_MAX_PAYLOAD, 32'hFFFF_FFFF);
                end
                1: begin
                    write_reg(CFG_EXPECTED_VERSION, 32'h0000_FFFF);
                    write_reg(CFG_MAX_PAYLOAD, 32'd0);
                end
                2: begin
                    write_reg(CFG_EXPECTED_VERSION, 32'($urandom_range(0, 65535)));
                    write_reg(CFG_MAX_PAYLOAD, 32'd12);
                end
                default: begin
                    write_reg(CFG_EXPECTED_VERSION, 32'(VERSION_RST));
                    write_reg(CFG_MAX_PAYLOAD, MAX_PAYLOAD_RST);
                end
            endcase
            start = bytes_sent;
            while (bytes_sent - start < RANDOM_BYTES / 4) random_frame();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_output
        t_result want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_items.size() == 0) begin
                errors++;
                $display("%0t: expected no item, actual is_status %0b byte %0h status %0d",
                         $time, out_if.is_status, out_if.payload_byte, out_if.status);
            end else begin
                want = expected_items.pop_front();
                check_field("is_status", 32'(want.is_status), 32'(out_if.is_status));
                check_field("payload_byte", 32'(want.payload_byte), 32'(out_if.payload_byte));
                check_field("status", 32'(want.status), 32'(out_if.status));
                check_field("msg_type", 32'(want.msg_type), 32'(out_if.msg_type));
                check_field("frame_flags", 32'(want.frame_flags), 32'(out_if.frame_flags));
                check_field("payload_length", want.payload_length, out_if.payload_length);
                if (want.is_status) status_seen[want.status]++;
                else payload_seen++;
            end
        end
    end

    initial begin : output_stall
        int       window;
        int       hold_left;
        t_rx_mode mode;
        out_if.ready = 1'b0;
        window    = 0;
        hold_left = 0;
        mode      = RX_OPEN;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                if (window == 0) begin
                    window = $urandom_range(4, 40);
                    mode   = t_rx_mode'($urandom_range(0, 3));
                end
                window--;
                case (mode)
                    RX_OPEN:   out_if.ready <= 1'b1;
                    RX_MOSTLY: out_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: out_if.ready <= ($urandom_range(0, 4) < 2);
                    default:   out_if.ready <= window[0];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d items still expected",
                     $time, cycles, expected_items.size());
            $display("crc32_frame_checker_core verification failed");
            $finish;
        end
    end

    initial begin : run
        int drain;
        in_if.valid     = 1'b0;
        in_if.data_byte = 8'd0;
        in_if.last      = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = CFG_EXPECTED_VERSION;
        cfg_if.data     = 32'd0;
        cfg_version     = VERSION_RST;
        cfg_max_payload = MAX_PAYLOAD_RST;
        clear_frame();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_valid_frames();
        test_frame_faults();
        test_config_limits();
        test_output_hold();
        test_random_traffic();

        in_if.valid <= 1'b0;
        drain = 0;
        while (expected_items.size() != 0 && drain < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (expected_items.size() != 0) begin
            errors++;
            $display("%0t: %0d items missing: expected is_status %0b status %0d, actual none",
                     $time, expected_items.size(), expected_items[0].is_status,
                     expected_items[0].status);
        end
        $display("Sent %0d bytes in %0d frames and noise runs; %0d payload items; stalled %0b",
                 bytes_sent, frames_sent, payload_seen, stall_seen);
        $display("Status ok/short/magic/version/long/size/crc/type: %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_MAGIC],
                 status_seen[ST_VERSION], status_seen[ST_TOO_LONG], status_seen[ST_SIZE],
                 status_seen[ST_CHECKSUM], status_seen[ST_TYPE]);
        if (errors == 0) begin
            $display("crc32_frame_checker_core verification clean");
        end else begin
            $display("crc32_frame_checker_core verification failed");
        end
        $finish;
    end

endmodule
